// ===== rtl/qte_pkg.sv =====
// shared widths, constants and helper functions of the quaternion to euler unit
package qte_pkg;

	// input sample width, signed q2.14
	localparam int QW = 16;
	// product width of two input samples
	localparam int PW = 32;
	// width of the doubled sums and differences (q28 operands)
	localparam int NW = 35;
	// width of the clamped asin argument, signed, magnitude up to 2^28
	localparam int SW = 30;
	// width of the magnitude of the asin argument
	localparam int MW = 29;
	// width of the radicand 2^56 - s^2
	localparam int RW = 57;
	// width of the square root result
	localparam int ROOT_W = 29;
	// number of root bits, one per square root stage
	localparam int SQ_STAGES = 29;
	// cordic datapath width
	localparam int CW = 37;
	// cordic angle accumulator width, q24 radians
	localparam int ZW = 29;
	// width of the rounded angle before saturation
	localparam int OW = 17;
	// length of the arctangent table
	localparam int TAB_LEN = 24;

	localparam logic signed [NW-1:0] ONE_Q28 = NW'(64'sd268435456);
	localparam logic signed [ZW-1:0] PI_Q24 = ZW'(64'sd52707179);
	localparam logic signed [OW-1:0] ROLL_LIM = OW'(64'sd12868);
	localparam logic signed [OW-1:0] PITCH_LIM = OW'(64'sd6434);
	localparam logic signed [ZW-1:0] HALF_LSB = ZW'(64'sd2048);

	// atan(2^-i) in q24, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q24(input int idx);
		logic [24:0] v;
		case (idx)
			0: v = 25'd13176795;
			1: v = 25'd7778716;
			2: v = 25'd4110060;
			3: v = 25'd2086331;
			4: v = 25'd1047214;
			5: v = 25'd524117;
			6: v = 25'd262123;
			7: v = 25'd131069;
			8: v = 25'd65536;
			9: v = 25'd32768;
			10: v = 25'd16384;
			11: v = 25'd8192;
			12: v = 25'd4096;
			13: v = 25'd2048;
			14: v = 25'd1024;
			15: v = 25'd512;
			16: v = 25'd256;
			17: v = 25'd128;
			18: v = 25'd64;
			19: v = 25'd32;
			20: v = 25'd16;
			21: v = 25'd8;
			22: v = 25'd4;
			23: v = 25'd2;
			default: v = 25'd0;
		endcase
		return signed'(ZW'(v));
	endfunction

	// round half up from q24 to q12, then saturate to +-lim
	function automatic logic signed [OW-1:0] round_sat(input logic signed [ZW-1:0] z,
			input logic signed [OW-1:0] lim);
		logic signed [ZW:0] sum;
		logic signed [OW-1:0] q;
		sum = (ZW+1)'(z) + (ZW+1)'(HALF_LSB);
		q = OW'(sum >>> 12);
		if (q > lim) begin
			q = lim;
		end else if (q < -lim) begin
			q = -lim;
		end
		return q;
	endfunction

endpackage

// ===== rtl/qte_isqrt.sv =====
// pipelined floor square root, one result bit per register stage
module qte_isqrt (
	input  logic                          clk,
	input  logic [qte_pkg::RW-1:0]        rad,
	output logic [qte_pkg::ROOT_W-1:0]    root
);

	localparam int N = qte_pkg::SQ_STAGES;
	localparam int TW = qte_pkg::RW + 1;

	logic [TW-1:0]               rem_s [0:N];
	logic [qte_pkg::ROOT_W-1:0]  res_s [0:N];

	// stage zero is the radicand itself
	assign rem_s[0] = TW'(rad);
	assign res_s[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam int K = N - 1 - i;
		logic [TW-1:0] trial;

		// (res + 2^k)^2 - res^2 = res * 2^(k+1) + 2^(2k)
		assign trial = (TW'(res_s[i]) << (K + 1)) | (TW'(1) << (2 * K));

		// restoring step for root bit k
		always_ff @(posedge clk) begin
			if (rem_s[i] >= trial) begin
				rem_s[i+1] <= rem_s[i] - trial;
				res_s[i+1] <= res_s[i] | (qte_pkg::ROOT_W'(1) << K);
			end else begin
				rem_s[i+1] <= rem_s[i];
				res_s[i+1] <= res_s[i];
			end
		end
	end

	assign root = res_s[N];

endmodule

// ===== rtl/qte_cordic.sv =====
// pipelined vectoring cordic giving the angle of (x, y) in q24 radians
module qte_cordic #(
	parameter int STEPS = 14
) (
	input  logic                              clk,
	input  logic signed [qte_pkg::CW-1:0]     y_in,
	input  logic signed [qte_pkg::CW-1:0]     x_in,
	output logic signed [qte_pkg::ZW-1:0]     z_out
);

	localparam int NS = (STEPS > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN : STEPS;

	logic signed [qte_pkg::CW-1:0] x_s [0:NS];
	logic signed [qte_pkg::CW-1:0] y_s [0:NS];
	logic signed [qte_pkg::ZW-1:0] z_s [0:NS];

	// left half plane: turn the vector by pi
	always_ff @(posedge clk) begin
		if (x_in < 0) begin
			z_s[0] <= (y_in >= 0) ? qte_pkg::PI_Q24 : -qte_pkg::PI_Q24;
			x_s[0] <= -x_in;
			y_s[0] <= -y_in;
		end else begin
			z_s[0] <= '0;
			x_s[0] <= x_in;
			y_s[0] <= y_in;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		localparam logic signed [qte_pkg::ZW-1:0] ANG = qte_pkg::atan_q24(i);

		// one micro-rotation toward the x axis, none when y is zero
		always_ff @(posedge clk) begin
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ANG;
			end else if (y_s[i] < 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ANG;
			end else begin
				x_s[i+1] <= x_s[i];
				y_s[i+1] <= y_s[i];
				z_s[i+1] <= z_s[i];
			end
		end
	end

	assign z_out = z_s[NS];

endmodule

// ===== rtl/quaternion_to_euler_angles_unit.sv =====
// quaternion to zyx euler angles, fully pipelined top level
//
// usage: drive q_x, q_y, q_z, q_w (signed q2.14) and raise start for one
// cycle; a transaction is taken at each rising edge with start high and busy
// low. busy is always low, so a new quaternion may enter on every cycle.
// the pipeline holds the product, sum and square registers, 29 square
// root stages for the pitch cosine, one pre-rotation and CORDIC_STEPS
// cordic stages (CORDIC_STEPS capped at 24), and one output register.
// roll and yaw wait in delay lines beside the root.
// throughput is one transaction per clock, set by the fully unrolled
// square root and cordic pipelines.
// the result appears on roll_angle, pitch_angle and yaw_angle (signed
// q3.12 radians, pitch q2.12) for exactly one cycle with done high; the
// receiver cannot stall the block, so results are never held.
// reset clears all valid bits; transactions in flight are dropped and
// no done strobe follows reset until a new transaction completes.
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [15:0]             q_x,
	input  logic signed [15:0]             q_y,
	input  logic signed [15:0]             q_z,
	input  logic signed [15:0]             q_w,
	output logic                           done,
	output logic signed [14:0]             roll_angle,
	output logic signed [13:0]             pitch_angle,
	output logic signed [14:0]             yaw_angle
);

	localparam int NS = (CORDIC_STEPS > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN : CORDIC_STEPS;
	localparam int DL = qte_pkg::SQ_STAGES;
	localparam int LAT = 3 + DL + 1 + NS + 1;
	localparam int NW = qte_pkg::NW;
	localparam int PW = qte_pkg::PW;
	localparam int CW = qte_pkg::CW;
	localparam int ZW = qte_pkg::ZW;
	localparam int OW = qte_pkg::OW;

	logic [LAT-1:0] vld_q;
	logic           accept;

	// stage 1 products
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	// stage 2 operands
	logic signed [NW-1:0] numr_s2, denr_s2, numy_s2, deny_s2;
	logic signed [qte_pkg::SW-1:0] s_s2;
	logic [qte_pkg::MW-1:0] sabs_s2;
	// stage 3 square
	logic signed [NW-1:0] numr_s3, denr_s3, numy_s3, deny_s3;
	logic signed [qte_pkg::SW-1:0] s_s3;
	logic [qte_pkg::RW-1:0] sq_s3;

	logic signed [NW-1:0] sumr, difr, sumy, dify;
	logic signed [NW-1:0] s_raw;
	logic signed [qte_pkg::SW-1:0] s_clamp;
	logic [qte_pkg::RW-1:0] rad;
	logic [qte_pkg::ROOT_W-1:0] root;

	// delay lines alongside the square root
	logic signed [NW-1:0] numr_d [0:DL];
	logic signed [NW-1:0] denr_d [0:DL];
	logic signed [NW-1:0] numy_d [0:DL];
	logic signed [NW-1:0] deny_d [0:DL];
	logic signed [qte_pkg::SW-1:0] s_d [0:DL];

	logic signed [ZW-1:0] zr, zp, zy;
	logic signed [OW-1:0] roll_r, pitch_r, yaw_r;
	logic signed [14:0] roll_q, yaw_q;
	logic signed [13:0] pitch_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// products of the components
	always_ff @(posedge clk) begin
		wx_s1 <= q_w * q_x;
		yz_s1 <= q_y * q_z;
		xx_s1 <= q_x * q_x;
		yy_s1 <= q_y * q_y;
		wy_s1 <= q_w * q_y;
		zx_s1 <= q_z * q_x;
		wz_s1 <= q_w * q_z;
		xy_s1 <= q_x * q_y;
		zz_s1 <= q_z * q_z;
	end

	// sums of products for the atan2 operands, and the doubled asin argument
	assign sumr = NW'(wx_s1) + NW'(yz_s1);
	assign difr = NW'(xx_s1) + NW'(yy_s1);
	assign sumy = NW'(wz_s1) + NW'(xy_s1);
	assign dify = NW'(yy_s1) + NW'(zz_s1);
	assign s_raw = (NW'(wy_s1) - NW'(zx_s1)) <<< 1;

	// clamp of the asin argument to +-1.0
	always_comb begin
		if (s_raw > qte_pkg::ONE_Q28) begin
			s_clamp = qte_pkg::SW'(qte_pkg::ONE_Q28);
		end else if (s_raw < -qte_pkg::ONE_Q28) begin
			s_clamp = -qte_pkg::SW'(qte_pkg::ONE_Q28);
		end else begin
			s_clamp = qte_pkg::SW'(s_raw);
		end
	end

	always_ff @(posedge clk) begin
		numr_s2 <= sumr <<< 1;
		denr_s2 <= qte_pkg::ONE_Q28 - (difr <<< 1);
		numy_s2 <= sumy <<< 1;
		deny_s2 <= qte_pkg::ONE_Q28 - (dify <<< 1);
		s_s2 <= s_clamp;
		sabs_s2 <= qte_pkg::MW'((s_clamp < 0) ? -s_clamp : s_clamp);
	end

	// square of the asin argument
	always_ff @(posedge clk) begin
		numr_s3 <= numr_s2;
		denr_s3 <= denr_s2;
		numy_s3 <= numy_s2;
		deny_s3 <= deny_s2;
		s_s3 <= s_s2;
		sq_s3 <= qte_pkg::RW'(sabs_s2) * qte_pkg::RW'(sabs_s2);
	end

	// cosine of pitch: floor sqrt of 2^56 - s^2
	assign rad = (qte_pkg::RW'(1) << 56) - sq_s3;

	qte_isqrt u_isqrt (
		.clk  (clk),
		.rad  (rad),
		.root (root)
	);

	assign numr_d[0] = numr_s3;
	assign denr_d[0] = denr_s3;
	assign numy_d[0] = numy_s3;
	assign deny_d[0] = deny_s3;
	assign s_d[0] = s_s3;

	for (genvar i = 0; i < DL; i++) begin : g_dly
		always_ff @(posedge clk) begin
			numr_d[i+1] <= numr_d[i];
			denr_d[i+1] <= denr_d[i];
			numy_d[i+1] <= numy_d[i];
			deny_d[i+1] <= deny_d[i];
			s_d[i+1] <= s_d[i];
		end
	end

	// three angle pipelines
	qte_cordic #(.STEPS(NS)) u_roll (
		.clk   (clk),
		.y_in  (CW'(numr_d[DL])),
		.x_in  (CW'(denr_d[DL])),
		.z_out (zr)
	);

	qte_cordic #(.STEPS(NS)) u_pitch (
		.clk   (clk),
		.y_in  (CW'(s_d[DL])),
		.x_in  (signed'(CW'(root))),
		.z_out (zp)
	);

	qte_cordic #(.STEPS(NS)) u_yaw (
		.clk   (clk),
		.y_in  (CW'(numy_d[DL])),
		.x_in  (CW'(deny_d[DL])),
		.z_out (zy)
	);

	// round to q12 and saturate
	assign roll_r = qte_pkg::round_sat(zr, qte_pkg::ROLL_LIM);
	assign pitch_r = qte_pkg::round_sat(zp, qte_pkg::PITCH_LIM);
	assign yaw_r = qte_pkg::round_sat(zy, qte_pkg::ROLL_LIM);

	always_ff @(posedge clk) begin
		roll_q <= roll_r[14:0];
		pitch_q <= pitch_r[13:0];
		yaw_q <= yaw_r[14:0];
	end

	assign done = vld_q[LAT-1];
	assign roll_angle = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle = yaw_q;

endmodule

// ===== rtl/qte_checker.sv =====
// port level checks of the quaternion to euler unit and their binding
module qte_checker #(
	parameter int CORDIC_STEPS = 14
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [14:0] roll_angle,
	input logic signed [13:0] pitch_angle,
	input logic signed [14:0] yaw_angle
);

	localparam int NS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int LAT = 34 + NS;

	// a result only follows a transaction taken a full latency earlier
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");

	// the pipeline never refuses a transaction
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// pitch stays within +-pi/2
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_angle <= 14'sd6434 && pitch_angle >= -14'sd6434))
		else $error("pitch out of range");

	// roll and yaw stay within +-pi
	a_ry_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (roll_angle <= 15'sd12868 && roll_angle >= -15'sd12868 &&
			yaw_angle <= 15'sd12868 && yaw_angle >= -15'sd12868))
		else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_angles_unit qte_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_qte_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.roll_angle  (roll_angle),
	.pitch_angle (pitch_angle),
	.yaw_angle   (yaw_angle)
);

// ===== verif/tb.sv =====
// self-checking testbench of the quaternion to euler angles unit
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic signed [15:0] x, y, z, w;
	} quat_t;

	typedef struct {
		logic signed [14:0] roll;
		logic signed [13:0] pitch;
		logic signed [14:0] yaw;
	} euler_t;

	localparam int STEPS = 14;
	localparam int LATENCY = 34 + STEPS;
	localparam int HOLD_AT = 200;
	localparam longint ATAN_Q24 [24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
		524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};
	localparam longint PI24 = 52707179;
	localparam longint UNIT_Q28 = 64'sd1 << 28;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [15:0] q_x = '0, q_y = '0, q_z = '0, q_w = '0;
	logic busy, done;
	logic signed [14:0] roll_angle, yaw_angle;
	logic signed [13:0] pitch_angle;

	quat_t pending_quats[$];
	euler_t expected_angles[$];
	int gap_left = 0;
	int accepted_count = 0;
	int error_count = 0;
	bit calm_stretch = 1'b0;

	quaternion_to_euler_angles_unit #(.CORDIC_STEPS(STEPS)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.q_x(q_x), .q_y(q_y), .q_z(q_z), .q_w(q_w), .done(done),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle)
	);

	always #6 clk = ~clk;

	// floor integer square root
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned rem, res, bitv;
		rem = v;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// cordic vectoring angle in q24
	function automatic longint vector_angle(input longint y, input longint x);
		longint acc, nx;
		acc = 0;
		if (x < 0) begin
			acc = (y >= 0) ? PI24 : -PI24;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				x = nx;
				acc += ATAN_Q24[i];
			end else if (y < 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				x = nx;
				acc -= ATAN_Q24[i];
			end
		end
		return acc;
	endfunction

	function automatic longint round_clamp(input longint a, input longint lim);
		longint q;
		q = (a + 2048) >>> 12;
		if (q > lim) q = lim;
		if (q < -lim) q = -lim;
		return q;
	endfunction

	function automatic euler_t predict_angles(input quat_t q);
		euler_t e;
		longint x, y, z, w, num, den, s, c;
		x = q.x;
		y = q.y;
		z = q.z;
		w = q.w;
		num = 2 * (w * x + y * z);
		den = UNIT_Q28 - 2 * (x * x + y * y);
		e.roll = 15'(round_clamp(vector_angle(num, den), 12868));
		s = 2 * (w * y - z * x);
		if (s > UNIT_Q28) s = UNIT_Q28;
		if (s < -UNIT_Q28) s = -UNIT_Q28;
		c = longint'(int_sqrt(longint'(64'd1 << 56) - s * s));
		e.pitch = 14'(round_clamp(vector_angle(s, c), 6434));
		num = 2 * (w * z + x * y);
		den = UNIT_Q28 - 2 * (y * y + z * z);
		e.yaw = 15'(round_clamp(vector_angle(num, den), 12868));
		return e;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_stretch || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result check and transaction acceptance
	always @(posedge clk) begin
		euler_t e;
		if (done) begin
			if (expected_angles.size() == 0) begin
				$error("result with no transaction outstanding");
				error_count++;
			end else begin
				e = expected_angles.pop_front();
				if (roll_angle !== e.roll) begin
					$error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
					error_count++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
					error_count++;
				end
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
					error_count++;
				end
			end
		end
		if (start && !busy && pending_quats.size() != 0) begin
			expected_angles.push_back(predict_angles(pending_quats.pop_front()));
			accepted_count++;
			if ($urandom_range(0, 39) == 0) calm_stretch = ~calm_stretch;
			gap_left = draw_gap();
		end
	end

	// driver, inputs change on the falling edge
	always @(negedge clk) begin
		if (!arst_n || pending_quats.size() == 0) begin
			start <= 1'b0;
		end else if (accepted_count == HOLD_AT && expected_angles.size() != 0) begin
			start <= 1'b0;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else begin
			start <= 1'b1;
			q_x <= pending_quats[0].x;
			q_y <= pending_quats[0].y;
			q_z <= pending_quats[0].z;
			q_w <= pending_quats[0].w;
		end
	end

	function automatic logic signed [15:0] rand_comp(input bit full);
		if (full) return 16'($urandom);
		return 16'(signed'($urandom_range(0, 32768)) - 16384);
	endfunction

	// unit-length quaternion with random direction
	function automatic quat_t rand_unit();
		quat_t q;
		real a, b, c, d, n;
		a = real'(int'($urandom_range(0, 2000))) - 1000.0;
		b = real'(int'($urandom_range(0, 2000))) - 1000.0;
		c = real'(int'($urandom_range(0, 2000))) - 1000.0;
		d = real'(int'($urandom_range(0, 2000))) - 1000.0;
		n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
		q.x = 16'($rtoi(16384.0 * a / n));
		q.y = 16'($rtoi(16384.0 * b / n));
		q.z = 16'($rtoi(16384.0 * c / n));
		q.w = 16'($rtoi(16384.0 * d / n));
		return q;
	endfunction

	initial begin
		quat_t q;
		int r;
		// identity, axis extremes, pi case, saturated asin, zero and full-scale patterns
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd16384});
		pending_quats.push_back('{16'sd0, -16'sd16384, 16'sd0, 16'sd16384});
		pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd0, 16'sd11585});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
		pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
		pending_quats.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767});
		pending_quats.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
		pending_quats.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
		pending_quats.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
		pending_quats.push_back('{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384});
		pending_quats.push_back('{16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
		// random part: mostly unit quaternions, some in range, some any pattern
		repeat (450) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				q = rand_unit();
			end else begin
				q.x = rand_comp(r >= 85);
				q.y = rand_comp(r >= 85);
				q.z = rand_comp(r >= 85);
				q.w = rand_comp(r >= 85);
			end
			pending_quats.push_back(q);
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_quats.size() == 0);
		wait (expected_angles.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 200000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/qte_pkg.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles_unit.sv
rtl/qte_checker.sv
verif/tb.sv
